// ===== hw/rtl/gtbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtbd_pkg: shared types and constants
// Sizes, action codes and the node memory request struct.
// ----------------------------------------------------------------------------
package gtbd_pkg;
  localparam int unsigned MaxVertices = 16;
  localparam int unsigned MaxEdges    = 64;
  localparam int unsigned NodeCap     = 2 * MaxEdges;
  localparam int unsigned VW          = 4;
  localparam int unsigned LinkW       = $clog2(NodeCap + 1);
  localparam int unsigned NodeAw      = $clog2(NodeCap);
  localparam int unsigned LabelW      = 16;

  typedef enum logic [1:0] {
    ActClear = 2'd0,
    ActLabel = 2'd1,
    ActEdge  = 2'd2,
    ActTrav  = 2'd3
  } action_e;

  localparam logic [1:0] CfgVertexCount = 2'd0;
  localparam logic [1:0] CfgOrder       = 2'd1;

  typedef struct packed {
    logic              we;
    logic [NodeAw-1:0] waddr;
    logic [VW-1:0]     wtarget;
    logic [LinkW-1:0]  wnext;
    logic [NodeAw-1:0] raddr;
  } node_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/gtbd_node_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtbd_node_mem: adjacency node store
// One write port, one registered read port; target and next link per node.
// ----------------------------------------------------------------------------
module gtbd_node_mem
  import gtbd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire node_req_t        req_i,
  output logic [VW-1:0]         rd_target_o,
  output logic [LinkW-1:0]      rd_next_o
);
  logic [VW+LinkW-1:0] mem_q [NodeCap];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= {req_i.wtarget, req_i.wnext};
    end
    {rd_target_o, rd_next_o} <= mem_q[req_i.raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/graph_traversal_bfs_dfs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_traversal_bfs_dfs: graph store with breadth/depth-first walk
// Loads an undirected adjacency-list graph and walks it from a start vertex.
// ----------------------------------------------------------------------------
// usage:
//   an item (action, vertex_a, vertex_b, label_value) is taken when start is
//   high and busy low. clear and set label leave the block idle and give no
//   result. add edge writes its two nodes, the second from SEdge2; a dropped
//   edge gives one result with error_o set. traverse emits one label per
//   reached vertex on valid_o, last_o on the final one.
//   cfg_valid_i/cfg_ready_i write vertex_count (index 0) or traversal_order
//   (index 1); write only while idle.
// timing:
//   a traversal's pace is set by the single registered read port of the node
//   memory that every link step goes through. results cannot be stalled: each
//   is shown for one cycle.
// reset:
//   async reset empties all lists and labels; node memory needs no clearing
//   since it is only read through links written after the last clear.
// ----------------------------------------------------------------------------
module graph_traversal_bfs_dfs
  import gtbd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        action_i,
  input  wire logic [VW-1:0]     vertex_a_i,
  input  wire logic [VW-1:0]     vertex_b_i,
  input  wire logic [LabelW-1:0] label_value_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [4:0]        cfg_data_i,
  output logic                   valid_o,
  output logic [LabelW-1:0]      label_o,
  output logic                   last_o,
  output logic                   error_o
);
  typedef enum logic [2:0] {
    SIdle, SEdge2, SPop, SRead, SWait, SCheck, SDone
  } state_e;

  state_e                 state_q;
  logic [4:0]             vcount_q;
  logic                   order_q;
  logic [LabelW-1:0]      labels_q [MaxVertices];
  logic [LinkW-1:0]       heads_q  [MaxVertices];
  logic [LinkW-1:0]       used_q;
  logic [MaxVertices-1:0] visited_q;
  logic [VW-1:0]          wq_q     [MaxVertices];  // bfs queue or dfs stack vertex
  logic [LinkW-1:0]       wlink_q  [MaxVertices];  // dfs stack cursor
  logic [VW:0]            qhead_q, qtail_q;
  logic [LinkW-1:0]       link_q;
  logic [VW-1:0]          ea_q, eb_q;
  logic                   pend_q;
  logic [LabelW-1:0]      pend_label_q;
  node_req_t              req;
  logic [VW-1:0]          rd_target;
  logic [LinkW-1:0]       rd_next;
  logic [4:0]             cnt;
  logic [VW-1:0]          top_idx;

  gtbd_node_mem u_mem (
    .clk_i       (clk_i),
    .req_i       (req),
    .rd_target_o (rd_target),
    .rd_next_o   (rd_next)
  );

  always_comb begin
    cnt = (vcount_q > 5'(MaxVertices)) ? 5'(MaxVertices) : vcount_q;
    if (cnt == 5'd0) cnt = 5'd1;
  end

  assign busy        = (state_q != SIdle);
  assign cfg_ready_o = !busy;
  assign top_idx     = VW'(qtail_q - 1'b1);

  always_comb begin
    req       = '0;
    req.raddr = NodeAw'(link_q - 1'b1);
    if (state_q == SIdle && start && action_i == ActEdge) begin
      req.we      = (vertex_a_i < cnt) && (vertex_b_i < cnt) &&
                    (used_q <= LinkW'(NodeCap - 2));
      req.waddr   = NodeAw'(used_q);
      req.wtarget = vertex_b_i;
      req.wnext   = heads_q[vertex_a_i];
    end else if (state_q == SEdge2) begin
      req.we      = 1'b1;
      req.waddr   = NodeAw'(used_q);
      req.wtarget = ea_q;
      req.wnext   = heads_q[eb_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      vcount_q     <= 5'd16;
      order_q      <= 1'b0;
      used_q       <= '0;
      visited_q    <= '0;
      qhead_q      <= '0;
      qtail_q      <= '0;
      link_q       <= '0;
      ea_q         <= '0;
      eb_q         <= '0;
      pend_q       <= 1'b0;
      pend_label_q <= '0;
      valid_o      <= 1'b0;
      label_o      <= '0;
      last_o       <= 1'b0;
      error_o      <= 1'b0;
      for (int i = 0; i < MaxVertices; i++) begin
        labels_q[i] <= '0;
        heads_q[i]  <= '0;
        wq_q[i]     <= '0;
        wlink_q[i]  <= '0;
      end
    end else begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      error_o <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (cfg_valid_i) begin
            unique case (cfg_index_i)
              CfgVertexCount: vcount_q <= cfg_data_i;
              CfgOrder:       order_q  <= cfg_data_i[0];
              default: ;
            endcase
          end
          if (start) begin
            unique case (action_e'(action_i))
              ActClear: begin
                for (int i = 0; i < MaxVertices; i++) heads_q[i] <= '0;
                used_q <= '0;
              end
              ActLabel: if (vertex_a_i < cnt) labels_q[vertex_a_i] <= label_value_i;
              ActEdge: begin
                if (req.we) begin
                  heads_q[vertex_a_i] <= used_q + 1'b1;
                  used_q <= used_q + 1'b1;
                  ea_q   <= vertex_a_i;
                  eb_q   <= vertex_b_i;
                  state_q <= SEdge2;
                end else begin
                  valid_o <= 1'b1;
                  label_o <= '0;
                  error_o <= 1'b1;
                end
              end
              ActTrav: begin
                if (vertex_a_i < cnt) begin
                  visited_q <= MaxVertices'(1) << vertex_a_i;
                  pend_q       <= 1'b1;
                  pend_label_q <= labels_q[vertex_a_i];
                  wq_q[0]    <= vertex_a_i;
                  wlink_q[0] <= heads_q[vertex_a_i];
                  qhead_q    <= '0;
                  qtail_q    <= (VW+1)'(1);
                  state_q    <= SPop;
                end
              end
              default: ;
            endcase
          end
        end
        SEdge2: begin
          heads_q[eb_q] <= used_q + 1'b1;
          used_q  <= used_q + 1'b1;
          state_q <= SIdle;
        end
        SPop: begin
          if (!order_q) begin
            if (qhead_q < qtail_q) begin
              link_q  <= heads_q[wq_q[VW'(qhead_q)]];
              qhead_q <= qhead_q + 1'b1;
              state_q <= SRead;
            end else state_q <= SDone;
          end else begin
            if (qtail_q != '0) begin
              link_q  <= wlink_q[top_idx];
              state_q <= SRead;
            end else state_q <= SDone;
          end
        end
        SRead: begin
          if (link_q == '0 || link_q > LinkW'(NodeCap)) begin
            if (order_q) qtail_q <= qtail_q - 1'b1;
            state_q <= SPop;
          end else state_q <= SWait;
        end
        SWait: state_q <= SCheck;
        SCheck: begin
          link_q <= rd_next;
          if (order_q) wlink_q[top_idx] <= rd_next;
          state_q <= order_q ? SPop : SRead;
          if ((5'(rd_target) < cnt) && !visited_q[rd_target] &&
              (qtail_q < (VW+1)'(MaxVertices))) begin
            valid_o      <= pend_q;
            label_o      <= pend_label_q;
            pend_q       <= 1'b1;
            pend_label_q <= labels_q[rd_target];
            visited_q[rd_target] <= 1'b1;
            wq_q[VW'(qtail_q)]    <= rd_target;
            wlink_q[VW'(qtail_q)] <= heads_q[rd_target];
            qtail_q <= qtail_q + 1'b1;
          end
        end
        SDone: begin
          valid_o <= pend_q;
          last_o  <= pend_q;
          label_o <= pend_label_q;
          pend_q  <= 1'b0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/gtbd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtbd_checker: port-level assertions
// Watches the result and handshake ports of the top level.
// ----------------------------------------------------------------------------
module gtbd_checker
  import gtbd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              busy,
  input wire logic              cfg_ready_o,
  input wire logic              valid_o,
  input wire logic              last_o,
  input wire logic              error_o,
  input wire logic [LabelW-1:0] label_o
);
  // error result carries a zero label and no last mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && error_o |-> label_o == '0 && !last_o)
    else $error("bad error result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !last_o && !error_o)
    else $error("flag without strobe");
  // after the last label the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy)
    else $error("busy after last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !busy)
    else $error("cfg ready while busy");
endmodule

bind graph_traversal_bfs_dfs gtbd_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy(busy), .cfg_ready_o(cfg_ready_o),
  .valid_o(valid_o), .last_o(last_o), .error_o(error_o), .label_o(label_o)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: graph store and breadth/depth-first walk
// Loads random undirected graphs, walks them in both orders under several
// vertex counts, and checks every label, last and error flag against a
// graph model kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  import gtbd_pkg::*;

  typedef struct {
    logic [1:0]        act;
    logic [VW-1:0]     va;
    logic [VW-1:0]     vb;
    logic [LabelW-1:0] val;
  } graph_item_t;

  typedef struct {
    logic [LabelW-1:0] label;
    logic              last;
    logic              error;
  } walk_result_t;

  localparam int CycleLimit = 900000;
  localparam int SettleCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic [VW-1:0] vertex_a_i = '0;
  logic [VW-1:0] vertex_b_i = '0;
  logic [LabelW-1:0] label_value_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [4:0] cfg_data_i = '0;
  logic valid_o;
  logic [LabelW-1:0] label_o;
  logic last_o;
  logic error_o;

  graph_traversal_bfs_dfs dut (
    .clk_i, .rst_ni, .start, .busy,
    .action_i, .vertex_a_i, .vertex_b_i, .label_value_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .valid_o, .label_o, .last_o, .error_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  graph_item_t  pend_items[$];
  walk_result_t exp_labels[$];
  int errors = 0;
  int accepted = 0;
  int seen = 0;
  int got_results = 0;
  int walks = 0;
  int cycles = 0;

  // graph model
  logic [4:0]        m_count = 5'd16;
  logic              m_order = 1'b0;
  logic [LabelW-1:0] m_labels [MaxVertices];
  logic [LinkW-1:0]  m_heads [MaxVertices];
  logic [VW-1:0]     m_target [NodeCap];
  logic [LinkW-1:0]  m_next [NodeCap];
  int                m_used = 0;

  initial begin
    for (int i = 0; i < MaxVertices; i++) begin
      m_labels[i] = '0;
      m_heads[i] = '0;
    end
  end

  function automatic int eff_vertices();
    int c;
    c = m_count;
    if (c > MaxVertices) c = MaxVertices;
    if (c == 0) c = 1;
    return c;
  endfunction

  function automatic void add_node(int from, int to);
    m_target[m_used] = to[VW-1:0];
    m_next[m_used] = m_heads[from];
    m_used++;
    m_heads[from] = LinkW'(m_used);
  endfunction

  function automatic void predict_walk(graph_item_t it);
    int cnt, n, head, tail, sp, v, link, t;
    logic [15:0] vis;
    int order_q[MaxVertices];
    int stk_v[MaxVertices];
    int stk_l[MaxVertices];
    logic [LabelW-1:0] outl[$];
    walk_result_t r;
    cnt = eff_vertices();
    case (it.act)
      ActClear: begin
        for (int i = 0; i < MaxVertices; i++) m_heads[i] = '0;
        m_used = 0;
      end
      ActLabel: begin
        if (it.va < cnt) m_labels[it.va] = it.val;
      end
      ActEdge: begin
        if (it.va >= cnt || it.vb >= cnt || m_used + 2 > NodeCap) begin
          r.label = '0; r.last = 1'b0; r.error = 1'b1;
          exp_labels.push_back(r);
        end else begin
          add_node(it.va, it.vb);
          add_node(it.vb, it.va);
        end
      end
      default: begin
        if (it.va < cnt) begin
          vis = '0;
          outl.push_back(m_labels[it.va]);
          vis[it.va] = 1'b1;
          if (!m_order) begin
            head = 0; tail = 1; order_q[0] = it.va;
            while (head < tail) begin
              v = order_q[head++];
              link = m_heads[v];
              while (link != 0) begin
                t = m_target[link-1];
                if (t < cnt && !vis[t] && tail < MaxVertices) begin
                  outl.push_back(m_labels[t]);
                  vis[t] = 1'b1;
                  order_q[tail++] = t;
                end
                link = m_next[link-1];
              end
            end
          end else begin
            sp = 1; stk_v[0] = it.va; stk_l[0] = m_heads[it.va];
            while (sp > 0) begin
              link = stk_l[sp-1];
              if (link == 0) begin
                sp--;
              end else begin
                t = m_target[link-1];
                stk_l[sp-1] = m_next[link-1];
                if (t < cnt && !vis[t] && sp < MaxVertices) begin
                  outl.push_back(m_labels[t]);
                  vis[t] = 1'b1;
                  stk_v[sp] = t; stk_l[sp] = m_heads[t];
                  sp++;
                end
              end
            end
          end
          n = outl.size();
          for (int i = 0; i < n; i++) begin
            r.label = outl[i]; r.last = (i == n - 1); r.error = 1'b0;
            exp_labels.push_back(r);
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
  endtask

  // monitor: items, config writes and results at the rising edge
  always @(posedge clk_i) begin
    walk_result_t e;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgVertexCount) m_count <= cfg_data_i;
        else if (cfg_index_i == CfgOrder) m_order <= cfg_data_i[0];
      end
      if (valid_o) begin
        got_results++;
        if (exp_labels.size() == 0) begin
          report_mismatch("unexpected result", label_o, 0);
        end else begin
          e = exp_labels.pop_front();
          if (label_o !== e.label) report_mismatch("label", label_o, e.label);
          if (last_o !== e.last) report_mismatch("last", last_o, e.last);
          if (error_o !== e.error) report_mismatch("error", error_o, e.error);
        end
      end
      if (start && !busy) begin
        predict_walk(pend_items.pop_front());
        if (pend_items.size() == 0) ; // nothing left to hand over
        accepted <= accepted + 1;
      end
    end
  end

  // driver: bursts of items with random gaps, changes at the falling edge
  int burst_left = 3;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (start && accepted == seen) begin
      // item still waiting for the block
    end else begin
      seen = accepted;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pend_items.size() > 0) begin
        start <= 1'b1;
        action_i <= pend_items[0].act;
        vertex_a_i <= pend_items[0].va;
        vertex_b_i <= pend_items[0].vb;
        label_value_i <= pend_items[0].val;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_item(action_e act, int a, int b, int val);
    graph_item_t it;
    it.act = act; it.va = a[VW-1:0]; it.vb = b[VW-1:0]; it.val = val[LabelW-1:0];
    pend_items.push_back(it);
  endtask

  task automatic drain();
    while (pend_items.size() != 0 || exp_labels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[4:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one graph session with random content, with random noise items when with_noise is set
  task automatic random_session(int cnt, int n_items, bit with_noise);
    int r;
    if ($urandom_range(0, 4) != 0) queue_item(ActClear, 0, 0, 0);
    for (int i = 0; i < cnt; i++) queue_item(ActLabel, i, $urandom, $urandom);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 9);
      if (with_noise && r == 0)
        queue_item(action_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
      else if (r < 6)
        queue_item(ActEdge, $urandom_range(0, cnt - 1), $urandom_range(0, cnt - 1), $urandom);
      else if (r < 7)
        queue_item(ActLabel, $urandom_range(0, cnt - 1), 0, $urandom);
      else
        queue_item(ActTrav, $urandom_range(0, cnt - 1), $urandom, $urandom);
    end
    queue_item(ActTrav, $urandom_range(0, cnt - 1), 0, 0);
  endtask

  initial begin
    int c;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: label extremes, edges, self loop, both orders
    queue_item(ActTrav, 0, 0, 0);
    queue_item(ActLabel, 0, 0, 16'hffff);
    queue_item(ActLabel, 15, 0, 16'h0000);
    queue_item(ActLabel, 10, 0, 16'h5a5a);
    queue_item(ActLabel, 3, 0, 16'ha5a5);
    queue_item(ActEdge, 0, 15, 0);
    queue_item(ActEdge, 0, 3, 0);
    queue_item(ActEdge, 3, 10, 0);
    queue_item(ActEdge, 10, 10, 0);
    queue_item(ActEdge, 1, 10, 0);
    queue_item(ActTrav, 0, 15, 0);
    queue_item(ActTrav, 15, 0, 0);
    drain();
    write_reg(CfgOrder, 1);
    queue_item(ActTrav, 0, 0, 0);
    queue_item(ActTrav, 10, 0, 0);
    drain();
    // smaller count: out-of-range edge, label and start; stale targets skipped
    write_reg(CfgVertexCount, 4);
    queue_item(ActEdge, 5, 1, 0);
    queue_item(ActEdge, 1, 9, 0);
    queue_item(ActLabel, 12, 0, 16'h1234);
    queue_item(ActTrav, 7, 0, 0);
    queue_item(ActTrav, 0, 0, 0);
    queue_item(ActTrav, 3, 0, 0);
    drain();
    write_reg(CfgVertexCount, 0);
    queue_item(ActTrav, 0, 0, 0);
    queue_item(ActTrav, 1, 0, 0);
    queue_item(ActEdge, 0, 0, 0);
    drain();
    // largest count field, then fill the node store past its end
    write_reg(CfgVertexCount, 31);
    write_reg(CfgOrder, 0);
    queue_item(ActClear, 0, 0, 0);
    for (int i = 0; i < MaxEdges + 2; i++)
      queue_item(ActEdge, $urandom_range(0, 15), $urandom_range(0, 15), 0);
    queue_item(ActTrav, 0, 0, 0);
    drain();
    write_reg(CfgOrder, 1);
    queue_item(ActTrav, 5, 0, 0);
    drain();

    // random sessions across counts and orders
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0: c = 16;
        1: c = $urandom_range(17, 31);
        2: c = $urandom_range(0, 3);
        default: c = $urandom_range(4, 16);
      endcase
      write_reg(CfgVertexCount, c);
      write_reg(CfgOrder, $urandom_range(0, 1));
      c = (c == 0) ? 1 : (c > 16 ? 16 : c);
      random_session(c, 12, 1'b1);
      if (ph == 4) drain();  // sender holds until every result is back
      random_session(c, 10, 1'b0);
      drain();
      // lower the count without clearing so old nodes point out of range
      if (ph % 3 == 0 && c > 2) begin
        write_reg(CfgVertexCount, $urandom_range(1, c - 1));
        queue_item(ActTrav, 0, 0, 0);
        drain();
      end
    end

    $display("walks and loads done: %0d items accepted, %0d results checked",
             accepted, got_results);
    $display("covered both orders, count extremes, dropped edges and stale nodes");
    if (errors == 0 && exp_labels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end
endmodule

// ===== files.f =====
hw/rtl/gtbd_pkg.sv
hw/rtl/gtbd_node_mem.sv
hw/rtl/graph_traversal_bfs_dfs.sv
hw/rtl/gtbd_checker.sv
tb/sv/testbench.sv
